// ===== design/note_strum_crossing_trigger_defines.svh =====
// ----------------------------------------------------------------------------
// note_strum_crossing_trigger_defines.svh
// Assertion macros used by the strum trigger top level.
// ----------------------------------------------------------------------------
`ifndef NOTE_STRUM_CROSSING_TRIGGER_DEFINES_SVH
`define NOTE_STRUM_CROSSING_TRIGGER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define NSCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsct assertion failed");

// Condition must never hold.
`define NSCT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nsct assertion failed");

`endif

// ===== design/nsct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsct_pkg
// Types and constants of the strum crossing note trigger.
// ----------------------------------------------------------------------------
package nsct_pkg;

    localparam int MAX_NOTES_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int POS_W         = 17;
    localparam int PITCH_W       = 7;
    localparam int CMD_DEPTH     = 2;
    localparam int RES_DEPTH     = 4;

    localparam logic [POS_W-1:0]   POS_ONE    = 17'd65536;
    localparam logic [POS_W-1:0]   WRAP_LIMIT = 17'd64881;
    localparam logic [PITCH_W-1:0] STRUM_VEL  = 7'd127;
    localparam logic [PITCH_W-1:0] VEL_OFF    = 7'd0;
    localparam logic               CMD_STRUM  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [PITCH_W-1:0] pitch;
        logic [PITCH_W-1:0] velocity;
        logic [POS_W-1:0]   strum_pos;
    } in_item_t;

    typedef struct packed {
        logic [PITCH_W-1:0] out_pitch;
        logic [PITCH_W-1:0] out_velocity;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_NOTE_ON,
        KIND_NOTE_OFF,
        KIND_STRUM
    } cmd_kind_t;

    // Classified command passed from front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [PITCH_W-1:0] pitch;
        logic               up;
        logic               fire;
        logic [POS_W-1:0]   old_pos;
        logic [POS_W-1:0]   new_pos;
    } cmd_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_OFF_EMIT,
        B_OFF_WALK,
        B_SETUP,
        B_WALK,
        B_FLUSH
    } back_state_t;

endpackage

// ===== design/note_strum_crossing_trigger.sv =====
`timescale 1ns / 1ps
// Path: a note-off result goes from the command queue via B_IDLE and B_OFF_EMIT to the
// result queue; a strum's first note-on goes out at the next hit, or in B_FLUSH if none.
// Order: a note-on is done in B_IDLE; a note-off adds B_OFF_EMIT and B_OFF_WALK, a strum
// B_SETUP, B_WALK and B_FLUSH; list walks read one entry a cycle, B_WALK holding on res_full.
// Reset: rst_n clears the note count, the previous strum position and both queues;
// the note list itself is left as is and needs no clearing pass.
// ----------------------------------------------------------------------------
// note_strum_crossing_trigger
// Strum crossing note trigger: held notes fire as the strum position sweeps.
// ----------------------------------------------------------------------------
`include "note_strum_crossing_trigger_defines.svh"

module note_strum_crossing_trigger
    import nsct_pkg::*;
#(
    parameter int MAX_NOTES = MAX_NOTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);
    localparam int CMD_W = $bits(cmd_item_t);
    localparam int RES_W = $bits(out_item_t);

    // Front to command queue.
    logic             cq_push;
    logic             cq_full;
    cmd_item_t        cq_in;

    // Command queue to back end.
    logic             cq_pop;
    logic             cq_empty;
    logic [CMD_W-1:0] cq_dout;

    // Back end to result queue.
    logic             res_push;
    logic             res_full;
    out_item_t        res_in;
    logic [RES_W-1:0] res_dout;

    // Front: classify each transfer, compute strum direction and the wraparound
    // test, and hold the previous strum position so the back end sees plain data.
    nsct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .cq_push (cq_push),
        .cq_item (cq_in),
        .cq_full (cq_full)
    );

    // Short queue between front and back so the front keeps taking items
    // while the back walks the note list.
    nsct_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_in),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    // Back: owns the note list, compacts it on note-off and walks it on strum.
    nsct_back #(
        .MAX_NOTES (MAX_NOTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd       (cmd_item_t'(cq_dout)),
        .cmd_pop   (cq_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue: decouple the walk from the consumer's pop pattern.
    nsct_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign result = out_item_t'(res_dout);

    // Back end must not push into a full result queue.
    `NSCT_ASSERT_NEVER(a_res_no_overflow, res_push && res_full)
    // Back end must not pop an empty command queue.
    `NSCT_ASSERT_NEVER(a_cmd_no_underflow, cq_pop && cq_empty)
    // A note-off is always a single, final result.
    `NSCT_ASSERT_IMP(a_off_is_last, !empty && (result.out_velocity == VEL_OFF), result.last)

endmodule

// ===== design/nsct_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsct_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module nsct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/nsct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsct_front
// Classify incoming items and track the previous strum position.
// ----------------------------------------------------------------------------
module nsct_front
    import nsct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    output logic      cq_push,
    output cmd_item_t cq_item,
    input  logic      cq_full
);
    logic [POS_W-1:0] prev_strum_reg, prev_strum_next;
    logic [POS_W-1:0] pos_sat;
    logic [POS_W-1:0] mag;
    logic             up;

    assign full    = cq_full;
    assign cq_push = push;

    // Saturate beyond 1.0, then find direction and distance.
    assign pos_sat = (item.strum_pos > POS_ONE) ? POS_ONE : item.strum_pos;
    assign up      = (pos_sat > prev_strum_reg);
    assign mag     = up ? (pos_sat - prev_strum_reg) : (prev_strum_reg - pos_sat);

    always_comb
    begin
        cq_item.pitch   = item.pitch;
        cq_item.up      = up;
        cq_item.fire    = (mag != '0) && (mag < WRAP_LIMIT);
        cq_item.old_pos = prev_strum_reg;
        cq_item.new_pos = pos_sat;
        if (item.cmd == CMD_STRUM)
        begin
            cq_item.kind = KIND_STRUM;
        end
        else if (item.velocity != VEL_OFF)
        begin
            cq_item.kind = KIND_NOTE_ON;
        end
        else
        begin
            cq_item.kind = KIND_NOTE_OFF;
        end
    end

    always_comb
    begin
        prev_strum_next = prev_strum_reg;
        if (push && !cq_full && (item.cmd == CMD_STRUM))
        begin
            prev_strum_next = pos_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_strum_reg <= '0;
        end
        else
        begin
            prev_strum_reg <= prev_strum_next;
        end
    end

endmodule

// ===== design/nsct_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsct_back
// Hold the note list, compact it on note-off, walk it on strum.
// ----------------------------------------------------------------------------
module nsct_back
    import nsct_pkg::*;
#(
    parameter int MAX_NOTES = MAX_NOTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    input  cmd_item_t cmd,
    output logic      cmd_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);
    localparam int IDX_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W  = $clog2(MAX_NOTES + 1);
    localparam int PROD_W = POS_W + CNT_W + 1;
    localparam int HIT_W  = $clog2(MAX_RESULTS + 1);

    logic [PITCH_W-1:0] mem [MAX_NOTES];
    logic [PITCH_W-1:0] rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    cmd_item_t          cur_reg, cur_next;
    logic [PROD_W-1:0]  old_reg, old_next;
    logic [PROD_W-1:0]  new_reg, new_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [PITCH_W-1:0] pend_pitch_reg, pend_pitch_next;
    logic [HIT_W-1:0]   hit_cnt_reg, hit_cnt_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [PITCH_W-1:0] mem_wdata;
    logic               walk_go;
    logic               hit;
    logic               at_end;
    logic [CNT_W-1:0]   cnt_m1;
    logic [PROD_W-1:0]  spot;
    logic [PROD_W-1:0]  two_n;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign at_end = (CNT_W'(idx_reg) == cnt_m1);
    assign spot   = PROD_W'({idx_reg, 1'b1, 16'b0});
    assign two_n  = PROD_W'({count_reg, 1'b0});
    assign hit    = cur_reg.up ? ((old_reg < spot) && (spot <= new_reg))
                               : ((new_reg <= spot) && (spot < old_reg));

    // Outputs of the sequencer.
    always_comb
    begin
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        res       = '{out_pitch: pend_pitch_reg, out_velocity: STRUM_VEL, last: 1'b0};
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = cmd.pitch;
        walk_go   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                cmd_pop = !cmd_empty;
                mem_we  = !cmd_empty && (cmd.kind == KIND_NOTE_ON)
                          && (count_reg < CNT_W'(MAX_NOTES));
            end
            B_OFF_EMIT:
            begin
                res_push = !res_full;
                res      = '{out_pitch: cur_reg.pitch, out_velocity: VEL_OFF, last: 1'b1};
            end
            B_OFF_WALK:
            begin
                mem_we    = (rd_data_reg != cur_reg.pitch);
                mem_waddr = wr_idx_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
            end
            B_SETUP:
            begin
                walk_go = 1'b0;
            end
            B_WALK:
            begin
                // Emit the held hit only once a later one proves it is not last.
                res_push = hit && pend_valid_reg && !res_full;
                walk_go  = !(hit && pend_valid_reg && res_full);
            end
            B_FLUSH:
            begin
                res_push = pend_valid_reg && !res_full;
                res.last = 1'b1;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Next state and datapath registers.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = '0;
        wr_idx_next     = wr_idx_reg;
        cur_next        = cur_reg;
        old_next        = old_reg;
        new_next        = new_reg;
        pend_valid_next = pend_valid_reg;
        pend_pitch_next = pend_pitch_reg;
        hit_cnt_next    = hit_cnt_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cur_next = cmd;
                    unique case (cmd.kind)
                        KIND_NOTE_ON:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_NOTE_OFF:
                        begin
                            state_next = B_OFF_EMIT;
                        end
                        KIND_STRUM:
                        begin
                            if (cmd.fire && (count_reg != '0))
                            begin
                                state_next = B_SETUP;
                            end
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_OFF_EMIT:
            begin
                wr_idx_next = '0;
                if (!res_full)
                begin
                    state_next = (count_reg == '0) ? B_IDLE : B_OFF_WALK;
                end
            end
            B_OFF_WALK:
            begin
                wr_idx_next = mem_we ? wr_idx_reg + 1'b1 : wr_idx_reg;
                if (at_end)
                begin
                    count_next = wr_idx_next;
                    state_next = B_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_SETUP:
            begin
                old_next        = PROD_W'(cur_reg.old_pos) * two_n;
                new_next        = PROD_W'(cur_reg.new_pos) * two_n;
                pend_valid_next = 1'b0;
                hit_cnt_next    = '0;
                state_next      = B_WALK;
            end
            B_WALK:
            begin
                idx_next = idx_reg;
                if (walk_go)
                begin
                    if (hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_pitch_next = rd_data_reg;
                        hit_cnt_next    = hit_cnt_reg + 1'b1;
                    end
                    if (at_end || (hit && (hit_cnt_reg == HIT_W'(MAX_RESULTS - 1))))
                    begin
                        idx_next   = '0;
                        state_next = B_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            B_FLUSH:
            begin
                if (!pend_valid_reg || !res_full)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            hit_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_idx_reg     <= wr_idx_next;
            pend_valid_reg <= pend_valid_next;
            hit_cnt_reg    <= hit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        old_reg        <= old_next;
        new_reg        <= new_next;
        pend_pitch_reg <= pend_pitch_next;
    end

    // Note list: one write port, registered read at the next walk index.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_next];
    end

endmodule
